// ===== rtl/cau_pkg.sv =====
// cau_pkg: shared types and constants of the complex arithmetic unit.
// Depends on nothing; cau_dpath, cau_ctrl, the top level and the testbench import it.
package cau_pkg;

   // opcodes of a request
   localparam logic [2:0] OP_ADD   = 3'd0;
   localparam logic [2:0] OP_SUB   = 3'd1;
   localparam logic [2:0] OP_MUL   = 3'd2;
   localparam logic [2:0] OP_DIV   = 3'd3;
   localparam logic [2:0] OP_POWER = 3'd4;
   localparam logic [2:0] OP_MOD   = 3'd5;
   localparam logic [2:0] OP_SQRT  = 3'd6;
   localparam logic [2:0] OP_EQ    = 3'd7;

   // result status codes
   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_DZ  = 2'd1;
   localparam logic [1:0] ST_OVF = 2'd2;

   // multiplier operand pairs; P is a (or the running power), Q is b (or a)
   localparam logic [2:0] MUL_PR_QR = 3'd0;
   localparam logic [2:0] MUL_PI_QI = 3'd1;
   localparam logic [2:0] MUL_PR_QI = 3'd2;
   localparam logic [2:0] MUL_PI_QR = 3'd3;
   localparam logic [2:0] MUL_QR_QR = 3'd4;
   localparam logic [2:0] MUL_QI_QI = 3'd5;
   localparam logic [2:0] MUL_PR_PR = 3'd6;
   localparam logic [2:0] MUL_PI_PI = 3'd7;

   // accumulator targets
   localparam logic [1:0] ACC_NONE = 2'd0;
   localparam logic [1:0] ACC_0    = 2'd1;
   localparam logic [1:0] ACC_1    = 2'd2;
   localparam logic [1:0] ACC_2    = 2'd3;

   localparam int unsigned MAX_EXPONENT = 255;
   localparam int unsigned DIV_STEPS    = 32;
   localparam int unsigned ROOT_STEPS   = 32;
   localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

   typedef struct packed {
      logic       load;
      logic       set_one;
      logic       fast_wr;
      logic [2:0] mul_sel;
      logic [1:0] acc_dst;
      logic       acc_add;
      logic       acc_neg;
      logic       cm_wr;
      logic       set_dz;
      logic       div_init;
      logic       div_step;
      logic       div_wr;
      logic       rt_init;
      logic       rt_step;
      logic       rt_wr;
      logic [1:0] part;
      logic       out_load;
   } cau_cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] exponent;
      logic       acc2_zero;
   } cau_sts_type;

endpackage

// ===== rtl/cau_req_if.sv =====
// cau_req_if: request channel of the complex arithmetic unit.
// Depends on nothing.
interface cau_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         req_type;
   logic signed [31:0] a_re;
   logic signed [31:0] a_im;
   logic signed [31:0] b_re;
   logic signed [31:0] b_im;
   logic [7:0]         exponent;

   modport source (output valid, req_type, a_re, a_im, b_re, b_im, exponent, input ready);
   modport sink   (input valid, req_type, a_re, a_im, b_re, b_im, exponent, output ready);
endinterface

// ===== rtl/cau_rsp_if.sv =====
// cau_rsp_if: result channel of the complex arithmetic unit.
// Depends on nothing.
interface cau_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] res_re;
   logic signed [31:0] res_im;
   logic               is_equal;
   logic [1:0]         status;

   modport source (output valid, res_re, res_im, is_equal, status, input ready);
   modport sink   (input valid, res_re, res_im, is_equal, status, output ready);
endinterface

// ===== rtl/complex_arithmetic_unit.sv =====
// complex_arithmetic_unit: top level; Q16.16 complex ALU built from a sequencer
// and a datapath. Depends on cau_pkg, cau_req_if, cau_rsp_if, cau_ctrl, cau_dpath.
//
//   channel   modport  direction  transfer carries
//   req_chan  sink     in         req_type, a_re, a_im, b_re, b_im, exponent
//   rsp_chan  source   out        res_re, res_im, is_equal, status
//
// All products share the one 32x32 multiplier; the divider and root unit
// are one-bit-per-cycle.
// One request is in work at a time; the next one is taken while the last
// result waits in the output register. Reset is synchronous and clears control only.
module complex_arithmetic_unit (
   input logic       clock,
   input logic       reset,
   cau_req_if.sink   req_chan,
   cau_rsp_if.source rsp_chan
);
   import cau_pkg::*;

   cau_cmd_type cmd;
   cau_sts_type sts;

   // sequencer: decides which datapath action runs each cycle
   cau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: operands, multiplier, accumulators, divider, root, output register
   cau_dpath u_dpath (
      .clock    (clock),
      .cmd      (cmd),
      .sts      (sts),
      .req_type (req_chan.req_type),
      .a_re     (req_chan.a_re),
      .a_im     (req_chan.a_im),
      .b_re     (req_chan.b_re),
      .b_im     (req_chan.b_im),
      .exponent (req_chan.exponent),
      .res_re   (rsp_chan.res_re),
      .res_im   (rsp_chan.res_im),
      .is_equal (rsp_chan.is_equal),
      .status   (rsp_chan.status)
   );

endmodule

// ===== rtl/cau_dpath.sv =====
// cau_dpath: operand registers, shared multiplier, accumulators, divider, root unit
// and output register. Driven by cau_ctrl commands; depends on cau_pkg.
module cau_dpath (
   input  logic                clock,
   input  cau_pkg::cau_cmd_type cmd,
   output cau_pkg::cau_sts_type sts,
   input  logic [2:0]          req_type,
   input  logic signed [31:0]  a_re,
   input  logic signed [31:0]  a_im,
   input  logic signed [31:0]  b_re,
   input  logic signed [31:0]  b_im,
   input  logic [7:0]          exponent,
   output logic signed [31:0]  res_re,
   output logic signed [31:0]  res_im,
   output logic                is_equal,
   output logic [1:0]          status
);
   import cau_pkg::*;

   logic [2:0]         op_ff;
   logic [7:0]         exp_ff;
   logic signed [31:0] ar_ff, ai_ff, br_ff, bi_ff;
   logic signed [31:0] x_re_ff, x_im_ff;
   logic               ovf_ff, dz_ff, eq_ff;
   logic signed [63:0] prod_ff;
   logic signed [64:0] acc0_ff, acc1_ff, acc2_ff;
   logic [63:0]        dv_rem_ff;
   logic [31:0]        dv_low_ff, dv_q_ff;
   logic               dv_neg_ff, dv_big_ff;
   logic [63:0]        rt_v_ff;
   logic [34:0]        rt_rem_ff;
   logic [31:0]        rt_root_ff, m_ff;
   logic signed [31:0] out_re_ff, out_im_ff;
   logic               out_eq_ff;
   logic [1:0]         out_st_ff;

   logic signed [31:0] p_re, p_im, q_re, q_im, mul_x, mul_y;
   logic signed [64:0] prod_ext, acc_val;
   logic signed [32:0] sum_re, sum_im, dif_re, dif_im;
   logic [32:0]        sat0, sat1, sat_a, sat_b, sat_div, sat_mod;
   logic signed [64:0] dv_src, dv_abs;
   logic [64:0]        dv_t, dv_d;
   logic [33:0]        h_sum;
   logic [31:0]        h_val;
   logic [34:0]        rt_r2, rt_trial;

   // {overflow, value} of a magnitude q with sign neg, saturated to 32 bits
   function automatic logic [32:0] sat_u(input logic neg, input logic [47:0] q);
      logic [32:0] r;
      if (neg) begin
         if (q > 48'h0000_8000_0000) r = {1'b1, 32'h8000_0000};
         else                        r = {1'b0, ~q[31:0] + 32'd1};
      end else begin
         if (q > 48'h0000_7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
         else                        r = {1'b0, q[31:0]};
      end
      return r;
   endfunction

   // rescale a Q32.32 sum to Q16.16, truncating toward zero
   function automatic logic [32:0] sat_q(input logic signed [64:0] acc);
      logic [64:0] mag;
      mag = acc[64] ? 65'(-acc) : 65'(acc);
      return sat_u(acc[64], mag[63:16]);
   endfunction

   function automatic logic [32:0] sat33(input logic signed [32:0] s);
      logic [32:0] r;
      if (s[32] != s[31]) r = {1'b1, s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF};
      else                r = {1'b0, s[31:0]};
      return r;
   endfunction

   assign sts.op        = op_ff;
   assign sts.exponent  = exp_ff;
   assign sts.acc2_zero = (acc2_ff == '0);

   always_comb begin
      if (op_ff == OP_POWER) begin
         p_re = x_re_ff; p_im = x_im_ff; q_re = ar_ff; q_im = ai_ff;
      end else begin
         p_re = ar_ff;   p_im = ai_ff;   q_re = br_ff; q_im = bi_ff;
      end
      unique case (cmd.mul_sel)
         MUL_PR_QR: begin mul_x = p_re; mul_y = q_re; end
         MUL_PI_QI: begin mul_x = p_im; mul_y = q_im; end
         MUL_PR_QI: begin mul_x = p_re; mul_y = q_im; end
         MUL_PI_QR: begin mul_x = p_im; mul_y = q_re; end
         MUL_QR_QR: begin mul_x = q_re; mul_y = q_re; end
         MUL_QI_QI: begin mul_x = q_im; mul_y = q_im; end
         MUL_PR_PR: begin mul_x = p_re; mul_y = p_re; end
         default:   begin mul_x = p_im; mul_y = p_im; end
      endcase
   end

   assign prod_ext = 65'(prod_ff);
   assign acc_val  = cmd.acc_neg ? -prod_ext : prod_ext;

   assign sum_re = 33'(ar_ff) + 33'(br_ff);
   assign sum_im = 33'(ai_ff) + 33'(bi_ff);
   assign dif_re = 33'(ar_ff) - 33'(br_ff);
   assign dif_im = 33'(ai_ff) - 33'(bi_ff);
   assign sat_a  = sat33((op_ff == OP_ADD) ? sum_re : dif_re);
   assign sat_b  = sat33((op_ff == OP_ADD) ? sum_im : dif_im);
   assign sat0   = sat_q(acc0_ff);
   assign sat1   = sat_q(acc1_ff);

   // divider: quotient of |n| * 2^16 / d, one bit per step
   assign dv_src  = cmd.part[0] ? acc1_ff : acc0_ff;
   assign dv_abs  = dv_src[64] ? -dv_src : dv_src;
   assign dv_d    = {1'b0, acc2_ff[63:0]};
   assign dv_t    = {dv_rem_ff, dv_low_ff[31]};
   assign sat_div = sat_u(dv_neg_ff, dv_big_ff ? 48'hFFFF_FFFF_FFFF : {16'd0, dv_q_ff});

   // root unit: two radicand bits per step
   assign h_sum    = cmd.part[1] ? ({2'b00, m_ff} - 34'(ar_ff)) : ({2'b00, m_ff} + 34'(ar_ff));
   assign h_val    = h_sum[32:1];
   assign rt_r2    = {rt_rem_ff[32:0], rt_v_ff[63:62]};
   assign rt_trial = {1'b0, rt_root_ff, 2'b01};
   assign sat_mod  = sat_u(1'b0, {16'd0, rt_root_ff});

   always_ff @(posedge clock) begin
      prod_ff <= mul_x * mul_y;

      if (cmd.load) begin
         op_ff   <= req_type;
         exp_ff  <= exponent;
         ar_ff   <= a_re;
         ai_ff   <= a_im;
         br_ff   <= b_re;
         bi_ff   <= b_im;
         x_re_ff <= a_re;
         x_im_ff <= a_im;
         ovf_ff  <= 1'b0;
         dz_ff   <= 1'b0;
         eq_ff   <= 1'b0;
      end

      unique case (cmd.acc_dst)
         ACC_0:   acc0_ff <= cmd.acc_add ? acc0_ff + acc_val : acc_val;
         ACC_1:   acc1_ff <= cmd.acc_add ? acc1_ff + acc_val : acc_val;
         ACC_2:   acc2_ff <= cmd.acc_add ? acc2_ff + acc_val : acc_val;
         default: ;
      endcase

      if (cmd.set_one) begin
         x_re_ff <= Q_ONE;
         x_im_ff <= '0;
      end

      if (cmd.fast_wr) begin
         if (op_ff == OP_EQ) begin
            x_re_ff <= '0;
            x_im_ff <= '0;
            eq_ff   <= (ar_ff == br_ff) && (ai_ff == bi_ff);
         end else begin
            x_re_ff <= sat_a[31:0];
            x_im_ff <= sat_b[31:0];
            ovf_ff  <= sat_a[32] | sat_b[32];
         end
      end

      if (cmd.cm_wr) begin
         x_re_ff <= sat0[31:0];
         x_im_ff <= sat1[31:0];
         ovf_ff  <= ovf_ff | sat0[32] | sat1[32];
      end

      if (cmd.set_dz) begin
         x_re_ff <= '0;
         x_im_ff <= '0;
         dz_ff   <= 1'b1;
      end

      if (cmd.div_init) begin
         dv_neg_ff <= dv_src[64];
         dv_big_ff <= ({16'd0, dv_abs[63:16]} >= acc2_ff[63:0]);
         dv_rem_ff <= {16'd0, dv_abs[63:16]};
         dv_low_ff <= {dv_abs[15:0], 16'd0};
         dv_q_ff   <= '0;
      end
      if (cmd.div_step) begin
         dv_low_ff <= {dv_low_ff[30:0], 1'b0};
         if (dv_t >= dv_d) begin
            dv_rem_ff <= 64'(dv_t - dv_d);
            dv_q_ff   <= {dv_q_ff[30:0], 1'b1};
         end else begin
            dv_rem_ff <= dv_t[63:0];
            dv_q_ff   <= {dv_q_ff[30:0], 1'b0};
         end
      end
      if (cmd.div_wr) begin
         if (cmd.part[0]) x_im_ff <= sat_div[31:0];
         else             x_re_ff <= sat_div[31:0];
         ovf_ff <= ovf_ff | sat_div[32];
      end

      if (cmd.rt_init) begin
         rt_v_ff    <= (cmd.part == 2'd0) ? acc2_ff[63:0] : {16'd0, h_val, 16'd0};
         rt_rem_ff  <= '0;
         rt_root_ff <= '0;
      end
      if (cmd.rt_step) begin
         rt_v_ff <= {rt_v_ff[61:0], 2'b00};
         if (rt_r2 >= rt_trial) begin
            rt_rem_ff  <= rt_r2 - rt_trial;
            rt_root_ff <= {rt_root_ff[30:0], 1'b1};
         end else begin
            rt_rem_ff  <= rt_r2;
            rt_root_ff <= {rt_root_ff[30:0], 1'b0};
         end
      end
      if (cmd.rt_wr) begin
         unique case (cmd.part)
            2'd0: begin
               m_ff <= rt_root_ff;
               if (op_ff == OP_MOD) begin
                  x_re_ff <= sat_mod[31:0];
                  x_im_ff <= '0;
                  ovf_ff  <= sat_mod[32];
               end
            end
            2'd1: x_re_ff <= rt_root_ff;
            default: x_im_ff <= ai_ff[31] ? -rt_root_ff : rt_root_ff;
         endcase
      end

      if (cmd.out_load) begin
         out_re_ff <= x_re_ff;
         out_im_ff <= x_im_ff;
         out_eq_ff <= eq_ff;
         out_st_ff <= dz_ff ? ST_DZ : (ovf_ff ? ST_OVF : ST_OK);
      end
   end

   assign res_re   = out_re_ff;
   assign res_im   = out_im_ff;
   assign is_equal = out_eq_ff;
   assign status   = out_st_ff;

endmodule

// ===== rtl/cau_ctrl.sv =====
// cau_ctrl: sequencer of the complex arithmetic unit; steps the datapath through
// each operation and owns both handshakes. Depends on cau_pkg.
module cau_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  cau_pkg::cau_sts_type sts,
   output cau_pkg::cau_cmd_type cmd
);
   import cau_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DISP   = 4'd1;
   localparam logic [3:0] S_MSEQ   = 4'd2;
   localparam logic [3:0] S_CMWR   = 4'd3;
   localparam logic [3:0] S_DCHK   = 4'd4;
   localparam logic [3:0] S_DVINIT = 4'd5;
   localparam logic [3:0] S_DVRUN  = 4'd6;
   localparam logic [3:0] S_DVWR   = 4'd7;
   localparam logic [3:0] S_RTINIT = 4'd8;
   localparam logic [3:0] S_RTRUN  = 4'd9;
   localparam logic [3:0] S_RTWR   = 4'd10;
   localparam logic [3:0] S_WB     = 4'd11;

   localparam logic [4:0] DIV_LAST  = 5'(DIV_STEPS - 1);
   localparam logic [4:0] ROOT_LAST = 5'(ROOT_STEPS - 1);

   logic [3:0] state_ff, state_in;
   logic [4:0] step_ff, step_in;
   logic [1:0] part_ff, part_in;
   logic [7:0] pw_cnt_ff, pw_cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] lim;
   logic [4:0] last_step;
   logic       is_cm, is_dv;

   assign is_cm = (sts.op == OP_MUL) || (sts.op == OP_POWER);
   assign is_dv = (sts.op == OP_DIV);
   assign last_step = is_cm ? 5'd4 : (is_dv ? 5'd6 : 5'd2);
   assign lim = (32'(sts.exponent) > MAX_EXPONENT) ? 8'(MAX_EXPONENT) : sts.exponent;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      part_in      = part_ff;
      pw_cnt_in    = pw_cnt_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd          = '0;
      cmd.part     = part_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               part_in  = '0;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            unique case (sts.op)
               OP_ADD, OP_SUB, OP_EQ: begin
                  cmd.fast_wr = 1'b1;
                  state_in    = S_WB;
               end
               OP_POWER: begin
                  pw_cnt_in = lim - 8'd1;
                  if (lim == 8'd0) begin
                     cmd.set_one = 1'b1;
                     state_in    = S_WB;
                  end else if (lim == 8'd1) begin
                     state_in = S_WB;
                  end else begin
                     state_in = S_MSEQ;
                  end
               end
               default: state_in = S_MSEQ;
            endcase
         end
         S_MSEQ: begin
            // multiplies issue one per cycle; each product is registered and summed in the cycle after it issues
            if (is_cm) begin
               unique case (step_ff)
                  5'd0: cmd.mul_sel = MUL_PR_QR;
                  5'd1: begin cmd.mul_sel = MUL_PI_QI; cmd.acc_dst = ACC_0; end
                  5'd2: begin
                     cmd.mul_sel = MUL_PR_QI; cmd.acc_dst = ACC_0;
                     cmd.acc_add = 1'b1;      cmd.acc_neg = 1'b1;
                  end
                  5'd3: begin cmd.mul_sel = MUL_PI_QR; cmd.acc_dst = ACC_1; end
                  default: begin cmd.acc_dst = ACC_1; cmd.acc_add = 1'b1; end
               endcase
            end else if (is_dv) begin
               unique case (step_ff)
                  5'd0: cmd.mul_sel = MUL_QR_QR;
                  5'd1: begin cmd.mul_sel = MUL_QI_QI; cmd.acc_dst = ACC_2; end
                  5'd2: begin
                     cmd.mul_sel = MUL_PR_QR; cmd.acc_dst = ACC_2; cmd.acc_add = 1'b1;
                  end
                  5'd3: begin cmd.mul_sel = MUL_PI_QI; cmd.acc_dst = ACC_0; end
                  5'd4: begin
                     cmd.mul_sel = MUL_PI_QR; cmd.acc_dst = ACC_0; cmd.acc_add = 1'b1;
                  end
                  5'd5: begin cmd.mul_sel = MUL_PR_QI; cmd.acc_dst = ACC_1; end
                  default: begin
                     cmd.acc_dst = ACC_1; cmd.acc_add = 1'b1; cmd.acc_neg = 1'b1;
                  end
               endcase
            end else begin
               unique case (step_ff)
                  5'd0: cmd.mul_sel = MUL_PR_PR;
                  5'd1: begin cmd.mul_sel = MUL_PI_PI; cmd.acc_dst = ACC_2; end
                  default: begin cmd.acc_dst = ACC_2; cmd.acc_add = 1'b1; end
               endcase
            end
            if (step_ff == last_step) begin
               step_in = '0;
               part_in = '0;
               if (is_cm)      state_in = S_CMWR;
               else if (is_dv) state_in = S_DCHK;
               else            state_in = S_RTINIT;
            end else begin
               step_in = step_ff + 5'd1;
            end
         end
         S_CMWR: begin
            cmd.cm_wr = 1'b1;
            if (sts.op == OP_POWER && pw_cnt_ff != 8'd1) begin
               pw_cnt_in = pw_cnt_ff - 8'd1;
               state_in  = S_MSEQ;
            end else begin
               state_in = S_WB;
            end
         end
         S_DCHK: begin
            if (sts.acc2_zero) begin
               cmd.set_dz = 1'b1;
               state_in   = S_WB;
            end else begin
               state_in = S_DVINIT;
            end
         end
         S_DVINIT: begin
            cmd.div_init = 1'b1;
            step_in      = '0;
            state_in     = S_DVRUN;
         end
         S_DVRUN: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 5'd1;
            if (step_ff == DIV_LAST) state_in = S_DVWR;
         end
         S_DVWR: begin
            cmd.div_wr = 1'b1;
            if (part_ff == 2'd0) begin
               part_in  = 2'd1;
               state_in = S_DVINIT;
            end else begin
               state_in = S_WB;
            end
         end
         S_RTINIT: begin
            cmd.rt_init = 1'b1;
            step_in     = '0;
            state_in    = S_RTRUN;
         end
         S_RTRUN: begin
            cmd.rt_step = 1'b1;
            step_in     = step_ff + 5'd1;
            if (step_ff == ROOT_LAST) state_in = S_RTWR;
         end
         S_RTWR: begin
            cmd.rt_wr = 1'b1;
            if ((part_ff == 2'd0 && sts.op == OP_MOD) || part_ff == 2'd2) begin
               state_in = S_WB;
            end else begin
               part_in  = part_ff + 2'd1;
               state_in = S_RTINIT;
            end
         end
         S_WB: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         part_ff      <= '0;
         pw_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         part_ff      <= part_in;
         pw_cnt_ff    <= pw_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sim/testbench.sv =====
// testbench: self-checking bench for complex_arithmetic_unit (Q16.16 complex ALU).
// Depends on cau_pkg, cau_req_if, cau_rsp_if and the block's RTL.
module testbench;
   import cau_pkg::*;

   typedef struct {
      logic [2:0]         op;
      logic signed [31:0] a_re, a_im, b_re, b_im;
      logic [7:0]         exponent;
   } alu_req_type;

   typedef struct {
      logic signed [31:0] re, im;
      logic               eq;
      logic [1:0]         status;
   } alu_rsp_type;

   logic clock = 0;
   logic reset = 1;
   always #1 clock = ~clock;

   cau_req_if req_chan ();
   cau_rsp_if rsp_chan ();

   complex_arithmetic_unit dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source)
   );

   alu_req_type pending_reqs[$];
   alu_rsp_type expected_rsps[$];
   int       mismatches = 0;
   int       src_idle_pct = 0;   // sender idle chance, percent
   int       snk_stall_pct = 0;  // receiver stall chance, percent
   bit       stim_done = 0;

   // ---------------- predictor: exact arithmetic in 130-bit signed ----------------
   typedef logic signed [129:0] wide_type;

   function automatic logic signed [31:0] sat32(wide_type v, ref bit ovf);
      if (v > 130'sd2147483647) begin
         ovf = 1;
         return 32'sh7FFF_FFFF;
      end
      if (v < -130'sd2147483648) begin
         ovf = 1;
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   // truncate toward zero on the >>16 rescale
   function automatic wide_type trunc_q16(wide_type v);
      wide_type m;
      m = (v < 0) ? -v : v;
      m = m >>> 16;
      return (v < 0) ? -m : m;
   endfunction

   function automatic logic [63:0] floor_sqrt(logic [127:0] v);
      logic [127:0] r;
      r = 0;
      for (int b = 63; b >= 0; b--) begin
         if ((r | (128'd1 << b)) * (r | (128'd1 << b)) <= v) r = r | (128'd1 << b);
      end
      return r[63:0];
   endfunction

   function automatic void complex_product(input logic signed [31:0] xr, xi, yr, yi,
                                           output logic signed [31:0] pr, pi,
                                           ref bit ovf);
      wide_type re, im;
      re = wide_type'(xr) * wide_type'(yr) - wide_type'(xi) * wide_type'(yi);
      im = wide_type'(xr) * wide_type'(yi) + wide_type'(xi) * wide_type'(yr);
      pr = sat32(trunc_q16(re), ovf);
      pi = sat32(trunc_q16(im), ovf);
   endfunction

   function automatic logic signed [31:0] q16_quotient(wide_type n, wide_type d, ref bit ovf);
      wide_type m, q;
      m = (n < 0) ? -n : n;
      q = (m <<< 16) / d;
      return sat32((n < 0) ? -q : q, ovf);
   endfunction

   function automatic alu_rsp_type predict_result(alu_req_type r);
      alu_rsp_type o;
      bit ovf;
      wide_type d, s, m, hr, hi;
      logic signed [31:0] tr, ti;
      ovf = 0;
      o = '{re: 0, im: 0, eq: 0, status: ST_OK};
      case (r.op)
         OP_ADD: begin
            o.re = sat32(wide_type'(r.a_re) + wide_type'(r.b_re), ovf);
            o.im = sat32(wide_type'(r.a_im) + wide_type'(r.b_im), ovf);
         end
         OP_SUB: begin
            o.re = sat32(wide_type'(r.a_re) - wide_type'(r.b_re), ovf);
            o.im = sat32(wide_type'(r.a_im) - wide_type'(r.b_im), ovf);
         end
         OP_MUL: complex_product(r.a_re, r.a_im, r.b_re, r.b_im, o.re, o.im, ovf);
         OP_DIV: begin
            d = wide_type'(r.b_re) * wide_type'(r.b_re) + wide_type'(r.b_im) * wide_type'(r.b_im);
            if (d == 0) o.status = ST_DZ;
            else begin
               o.re = q16_quotient(wide_type'(r.a_re) * wide_type'(r.b_re)
                                   + wide_type'(r.a_im) * wide_type'(r.b_im), d, ovf);
               o.im = q16_quotient(wide_type'(r.a_im) * wide_type'(r.b_re)
                                   - wide_type'(r.a_re) * wide_type'(r.b_im), d, ovf);
            end
         end
         OP_POWER: begin
            if (r.exponent == 0) o.re = Q_ONE;
            else begin
               o.re = r.a_re;
               o.im = r.a_im;
               for (int k = 1; k < r.exponent && k < MAX_EXPONENT; k++) begin
                  complex_product(o.re, o.im, r.a_re, r.a_im, tr, ti, ovf);
                  o.re = tr;
                  o.im = ti;
               end
            end
         end
         OP_MOD: begin
            s = wide_type'(r.a_re) * wide_type'(r.a_re) + wide_type'(r.a_im) * wide_type'(r.a_im);
            o.re = sat32(wide_type'({1'b0, floor_sqrt(s[127:0])}), ovf);
         end
         OP_SQRT: begin
            s = wide_type'(r.a_re) * wide_type'(r.a_re) + wide_type'(r.a_im) * wide_type'(r.a_im);
            m = wide_type'({1'b0, floor_sqrt(s[127:0])});
            hr = (m + r.a_re) >>> 1;
            hi = (m - r.a_re) >>> 1;
            o.re = 32'(floor_sqrt(hr[127:0] << 16));
            o.im = 32'(floor_sqrt(hi[127:0] << 16));
            if (r.a_im < 0) o.im = -o.im;
         end
         default: o.eq = (r.a_re == r.b_re) && (r.a_im == r.b_im);
      endcase
      if (o.status == ST_OK && ovf) o.status = ST_OVF;
      return o;
   endfunction

   // ---------------- driver ----------------
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid    <= 0;
         req_chan.req_type <= OP_ADD;
         req_chan.a_re     <= 0;
         req_chan.a_im     <= 0;
         req_chan.b_re     <= 0;
         req_chan.b_im     <= 0;
         req_chan.exponent <= 0;
      end else if (!req_chan.valid || req_chan.ready) begin
         // previous transfer done (or none); predict it, then maybe load next
         if (req_chan.valid)
            expected_rsps.push_back(predict_result('{req_chan.req_type, req_chan.a_re,
               req_chan.a_im, req_chan.b_re, req_chan.b_im, req_chan.exponent}));
         if (pending_reqs.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
            alu_req_type r;
            r = pending_reqs.pop_front();
            req_chan.valid    <= 1;
            req_chan.req_type <= r.op;
            req_chan.a_re     <= r.a_re;
            req_chan.a_im     <= r.a_im;
            req_chan.b_re     <= r.b_re;
            req_chan.b_im     <= r.b_im;
            req_chan.exponent <= r.exponent;
         end else begin
            req_chan.valid <= 0;
         end
      end
   end

   // ---------------- monitor ----------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result transfer: exp none got re=%h im=%h eq=%b st=%0d",
                           rsp_chan.res_re, rsp_chan.res_im, rsp_chan.is_equal,
                           rsp_chan.status);
            end else begin
               alu_rsp_type e;
               e = expected_rsps.pop_front();
               if (rsp_chan.res_re !== e.re || rsp_chan.res_im !== e.im
                   || rsp_chan.is_equal !== e.eq || rsp_chan.status !== e.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp re=%h im=%h eq=%b st=%0d got re=%h im=%h eq=%b st=%0d",
                              e.re, e.im, e.eq, e.status, rsp_chan.res_re, rsp_chan.res_im,
                              rsp_chan.is_equal, rsp_chan.status);
               end
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
   end

   // ---------------- stimulus ----------------
   function automatic logic signed [31:0] rand_operand();
      case ($urandom_range(5))
         0: return $urandom;
         1: return $signed($urandom_range(32'h3_0000)) - 32'sh1_8000;  // within +/-1.5 in Q16.16
         2: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         3: return 0;
         default: return $signed($urandom) >>> $urandom_range(20, 8);
      endcase
   endfunction

   task automatic queue_req(logic [2:0] op, logic signed [31:0] ar, ai, br, bi,
                            logic [7:0] ex);
      pending_reqs.push_back('{op, ar, ai, br, bi, ex});
   endtask

   task automatic run_phase(int idle, int stall, int count);
      alu_req_type r;
      src_idle_pct = idle;
      snk_stall_pct = stall;
      repeat (count) begin
         r.op = 3'($urandom_range(7));
         r.a_re = rand_operand();
         r.a_im = rand_operand();
         r.b_re = rand_operand();
         r.b_im = rand_operand();
         // mostly small exponents; power cost grows with it
         r.exponent = ($urandom_range(15) == 0) ? 8'($urandom) : 8'($urandom_range(6));
         if (r.op == OP_EQ && $urandom_range(1)) begin
            r.b_re = r.a_re;
            r.b_im = r.a_im;
         end
         if (r.op == OP_DIV && $urandom_range(9) == 0) begin
            r.b_re = 0;
            r.b_im = 0;
         end
         pending_reqs.push_back(r);
      end
      wait (pending_reqs.size() == 0);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;

      // directed: extremes, every opcode and the named special cases
      queue_req(OP_ADD, 32'sh7FFF_FFFF, 32'sh8000_0000, 1, -1, 0);     // saturate both ways
      queue_req(OP_SUB, 32'sh8000_0000, 32'sh7FFF_FFFF, 1, -1, 8'hFF);
      queue_req(OP_ADD, 32'sh0001_0000, 32'sh0002_0000, -5, 7, 0);
      queue_req(OP_MUL, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0);
      queue_req(OP_MUL, 32'sh0002_0000, 32'sh0003_0000, 32'sh0001_8000, -32'sh0000_4000, 0);
      queue_req(OP_DIV, 32'sh0001_0000, 0, 0, 0, 0);                     // divide by zero
      queue_req(OP_DIV, 32'sh0003_0000, 0, 32'sh0001_0000, 32'sh0001_0000, 0); // real / complex
      queue_req(OP_DIV, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1, 0, 0);        // quotient overflow
      queue_req(OP_DIV, -32'sh0005_0000, 32'sh0002_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 0);
      queue_req(OP_POWER, 32'sh0001_8000, 32'sh0000_8000, 0, 0, 0);      // power zero
      queue_req(OP_POWER, 32'sh0001_0000, 32'sh0001_0000, 0, 0, 8'd1);
      queue_req(OP_POWER, 32'sh0001_0000, 32'sh0001_0000, 0, 0, 8'd5);
      queue_req(OP_POWER, 32'sh0002_0000, 0, 0, 0, 8'hFF);               // sticky overflow
      queue_req(OP_POWER, 32'sh0000_FF00, -32'sh0000_0100, 0, 0, 8'hFF);
      queue_req(OP_MOD, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0);        // modulus saturates
      queue_req(OP_MOD, 32'sh0003_0000, -32'sh0004_0000, 0, 0, 0);
      queue_req(OP_SQRT, -32'sh0004_0000, 0, 0, 0, 0);                   // negative real
      queue_req(OP_SQRT, 32'sh0004_0000, 0, 0, 0, 0);
      queue_req(OP_SQRT, 32'sh0003_0000, -32'sh0004_0000, 0, 0, 0);      // negative imag
      queue_req(OP_SQRT, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 0);
      queue_req(OP_EQ, 32'sh1234_5678, -9, 32'sh1234_5678, -9, 0);
      queue_req(OP_EQ, 32'sh1234_5678, -9, 32'sh1234_5678, -8, 0);
      queue_req(OP_EQ, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
      wait (pending_reqs.size() == 0);

      // random: phases with and without sender idling and receiver stalls
      run_phase(0, 0, 200);
      run_phase(78, 0, 150);
      run_phase(0, 78, 150);
      run_phase(33, 33, 150);
      run_phase(0, 0, 100);
      stim_done = 1;
   end

   // ---------------- end of run ----------------
   initial begin
      wait (stim_done);
      // the last popped item still needs its transfer
      wait (!req_chan.valid && expected_rsps.size() == 0);
      repeat (300) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("PASS complex_arithmetic_unit");
      else
         $display("FAIL complex_arithmetic_unit");
      $finish;
   end

   // bound sized for the slowest power items plus receiver stalls on each item
   initial begin
      #4000000;
      $display("FAIL complex_arithmetic_unit");
      $finish;
   end
endmodule

// ===== files.f =====
rtl/cau_pkg.sv
rtl/cau_req_if.sv
rtl/cau_rsp_if.sv
rtl/cau_dpath.sv
rtl/cau_ctrl.sv
rtl/complex_arithmetic_unit.sv
sim/testbench.sv
